>>> src/ffha_pkg.sv
`timescale 1ns / 1ps
// ffha_pkg: constants, codes and the table entry type of the first-fit heap allocator
// no dependencies
`default_nettype none
package ffha_pkg;

    localparam int MAX_BLOCKS    = 256;
    localparam int HEADER_BYTES  = 40;
    localparam int INITIAL_BYTES = 65536;
    localparam int PAGE_BYTES    = 4096;
    localparam int ALIGN_BYTES   = 16;
    localparam int SPLIT_SLACK   = 16;

    localparam int IDX_W    = $clog2(MAX_BLOCKS);
    localparam int CNT_W    = IDX_W + 1;
    localparam int ACTION_W = 2;
    localparam int REQ_W    = 27;
    localparam int ADDR_W   = 26;
    localparam int STATUS_W = 2;
    localparam int TOT_W    = 27;
    localparam int START_W  = 27;
    localparam int SIZE_W   = 28;
    localparam int CALC_W   = 29;

    localparam int INIT_ROUND = ((INITIAL_BYTES + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
    localparam logic [TOT_W-1:0] LIMIT_RESET = TOT_W'(67108864);

    localparam int IN_DATA_W  = ((ACTION_W + REQ_W + ADDR_W + 7) / 8) * 8;
    localparam int OUT_BITS   = STATUS_W + ADDR_W + 1 + TOT_W + TOT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_RESIZE = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_MEM   = 2'd1,
        ST_NULL_REQ = 2'd2,
        ST_BAD_ADDR = 2'd3
    } status_t;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [SIZE_W-1:0]  size;
        logic               free;
    } entry_t;

    localparam entry_t RESET_ENTRY = '{
        start: '0,
        size:  SIZE_W'(INIT_ROUND - HEADER_BYTES),
        free:  1'b1
    };

endpackage
`default_nettype wire

>>> src/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// first_fit_heap_allocator: address-ordered block table in one synchronous ram,
// scanned and shifted by a sequencer; depends on ffha_pkg
//
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    tdata request, tuser has_address
//  m_*      out  m_tvalid / m_tready    tdata response
//  cfg_*    in   cfg_valid / cfg_ready  heap limit in bytes
//
// one request at a time: each table entry visited is read through the one ram read port,
// and a split or merge moves the entries behind it one by one; the longest path is a
// moving resize (address scan, fit scan, grow and rescan, insert, rescan, two merges)
// reset leaves one free block spanning the initial heap; entry 0 reads as that block
// until first written, so no clearing pass is needed
// a response waiting on m_tready holds the sequencer in its final step only
`default_nettype none
module first_fit_heap_allocator
    import ffha_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // action[1:0], request_size[28:2], address_offset[54:29], zero fill
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // has_address[0]
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // status[1:0], result_offset[27:2], moved[28], used_bytes[55:29],
    // free_bytes[82:56], zero fill
    output logic [OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [TOT_W-1:0]      cfg_data
);

    typedef enum logic [19:0] {
        S_IDLE    = 20'h00001,
        S_AD_RD   = 20'h00002,
        S_AD_CK   = 20'h00004,
        S_FF_RD   = 20'h00008,
        S_FF_CK   = 20'h00010,
        S_G_CALC  = 20'h00020,
        S_G_LIM   = 20'h00040,
        S_G_CK    = 20'h00080,
        S_SPLIT   = 20'h00100,
        S_IS_RD   = 20'h00200,
        S_IS_WR   = 20'h00400,
        S_IS_NEW  = 20'h00800,
        S_ALLOC_K = 20'h01000,
        S_FR_ST   = 20'h02000,
        S_FR_NX   = 20'h04000,
        S_FR_PVRD = 20'h08000,
        S_FR_PV   = 20'h10000,
        S_RM_RD   = 20'h20000,
        S_RM_WR   = 20'h40000,
        S_DONE    = 20'h80000
    } state_t;

    typedef enum logic [1:0] {
        P_FREE     = 2'd0,
        P_RESIZE   = 2'd1,
        P_MOVEFREE = 2'd2
    } purpose_t;

    entry_t mem [MAX_BLOCKS];
    logic [IDX_W-1:0] rd_addr;
    entry_t rd_data_reg;
    logic rd_init_reg;
    entry_t rd_q;
    logic mem_we;
    logic [IDX_W-1:0] mem_wa;
    entry_t mem_wd;

    state_t state_reg, state_next;
    purpose_t purpose_reg, purpose_next;
    logic moving_reg, moving_next;
    logic grown_reg, grown_next;
    logic rm_done_reg, rm_done_next;
    logic init0_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] k_reg, k_next;
    entry_t e_reg, e_next;
    entry_t new_reg, new_next;
    logic [REQ_W-1:0] req_reg, req_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [SIZE_W-1:0] s_reg, s_next;
    logic [CALC_W-1:0] grow_reg, grow_next;
    logic [TOT_W-1:0] heap_end_reg, heap_end_next;
    logic [TOT_W-1:0] used_reg, used_next;
    logic [TOT_W-1:0] free_reg, free_next;
    logic [TOT_W-1:0] limit_reg;
    status_t status_reg, status_next;
    logic [ADDR_W-1:0] off_reg, off_next;
    logic moved_reg, moved_next;
    logic out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic [SIZE_W-1:0] rem;
    logic [CALC_W-1:0] g0;
    logic [CALC_W-1:0] g1;

    // table ram
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init0_reg   <= 1'b1;
            rd_init_reg <= 1'b0;
        end
        else
        begin
            rd_init_reg <= init0_reg && (rd_addr == '0);
            if (mem_we && mem_wa == '0)
            begin
                init0_reg <= 1'b0;
            end
        end
    end

    assign rd_q = rd_init_reg ? RESET_ENTRY : rd_data_reg;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        purpose_next   = purpose_reg;
        moving_next    = moving_reg;
        grown_next     = grown_reg;
        rm_done_next   = rm_done_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        e_next         = e_reg;
        new_next       = new_reg;
        req_next       = req_reg;
        addr_next      = addr_reg;
        s_next         = s_reg;
        grow_next      = grow_reg;
        heap_end_next  = heap_end_reg;
        used_next      = used_reg;
        free_next      = free_reg;
        status_next    = status_reg;
        off_next       = off_reg;
        moved_next     = moved_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        rd_addr        = '0;
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_wd         = e_reg;
        rem            = rd_q.size - s_reg;
        g0             = CALC_W'(s_reg) + CALC_W'(HEADER_BYTES);
        g1             = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next    = s_tdata[ACTION_W +: REQ_W];
                    addr_next   = s_tdata[ACTION_W + REQ_W +: ADDR_W];
                    s_next      = SIZE_W'((CALC_W'(s_tdata[ACTION_W +: REQ_W])
                                  + CALC_W'(ALIGN_BYTES - 1)) & ~CALC_W'(ALIGN_BYTES - 1));
                    status_next = ST_NULL_REQ;
                    off_next    = '0;
                    moved_next  = 1'b0;
                    moving_next = 1'b0;
                    grown_next  = 1'b0;
                    i_next      = '0;
                    state_next  = S_DONE;
                    case (action_t'(s_tdata[ACTION_W-1:0]))
                        ACT_ALLOC:
                        begin
                            if (s_tdata[ACTION_W +: REQ_W] != '0)
                            begin
                                state_next = S_FF_RD;
                            end
                        end
                        ACT_FREE:
                        begin
                            if (s_tuser)
                            begin
                                purpose_next = P_FREE;
                                state_next   = S_AD_RD;
                            end
                        end
                        ACT_RESIZE:
                        begin
                            if (!s_tuser)
                            begin
                                if (s_tdata[ACTION_W +: REQ_W] != '0)
                                begin
                                    state_next = S_FF_RD;
                                end
                            end
                            else if (s_tdata[ACTION_W +: REQ_W] != '0)
                            begin
                                purpose_next = P_RESIZE;
                                state_next   = S_AD_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_AD_RD:
            begin
                rd_addr = i_reg[IDX_W-1:0];
                if (i_reg >= cnt_reg)
                begin
                    if (purpose_reg != P_MOVEFREE)
                    begin
                        status_next = ST_BAD_ADDR;
                    end
                    else
                    begin
                        moved_next = 1'b1;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_AD_CK;
                end
            end
            S_AD_CK:
            begin
                if (SIZE_W'(rd_q.start) + SIZE_W'(HEADER_BYTES) == SIZE_W'(addr_reg))
                begin
                    k_next = i_reg[IDX_W-1:0];
                    e_next = rd_q;
                    if (rd_q.free)
                    begin
                        status_next = ST_BAD_ADDR;
                        state_next  = S_DONE;
                    end
                    else if (purpose_reg == P_RESIZE)
                    begin
                        if (rd_q.size >= SIZE_W'(req_reg))
                        begin
                            status_next = ST_OK;
                            off_next    = addr_reg;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            moving_next = 1'b1;
                            i_next      = '0;
                            state_next  = S_FF_RD;
                        end
                    end
                    else
                    begin
                        state_next = S_FR_ST;
                    end
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_AD_RD;
                end
            end
            S_FF_RD:
            begin
                rd_addr = i_reg[IDX_W-1:0];
                if (i_reg >= cnt_reg)
                begin
                    if (grown_reg)
                    begin
                        status_next = ST_NO_MEM;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_G_CALC;
                    end
                end
                else
                begin
                    state_next = S_FF_CK;
                end
            end
            S_FF_CK:
            begin
                if (rd_q.free && rd_q.size >= s_reg)
                begin
                    k_next     = i_reg[IDX_W-1:0];
                    e_next     = rd_q;
                    state_next = S_SPLIT;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_FF_RD;
                end
            end
            S_G_CALC:
            begin
                if (g0 < CALC_W'(PAGE_BYTES))
                begin
                    g0 = CALC_W'(PAGE_BYTES);
                end
                g1 = (g0 + CALC_W'(PAGE_BYTES - 1)) & ~CALC_W'(PAGE_BYTES - 1);
                grow_next  = g1;
                state_next = S_G_LIM;
            end
            S_G_LIM:
            begin
                rd_addr = IDX_W'(cnt_reg - 1'b1);
                if (CALC_W'(heap_end_reg) + grow_reg > CALC_W'(limit_reg))
                begin
                    status_next = ST_NO_MEM;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_G_CK;
                end
            end
            S_G_CK:
            begin
                if (rd_q.free || cnt_reg < CNT_W'(MAX_BLOCKS))
                begin
                    mem_we = 1'b1;
                    if (rd_q.free)
                    begin
                        mem_wa = IDX_W'(cnt_reg - 1'b1);
                        mem_wd = '{start: rd_q.start,
                                   size: rd_q.size + SIZE_W'(grow_reg), free: 1'b1};
                    end
                    else
                    begin
                        mem_wa   = IDX_W'(cnt_reg);
                        mem_wd   = '{start: START_W'(heap_end_reg),
                                     size: SIZE_W'(grow_reg - CALC_W'(HEADER_BYTES)),
                                     free: 1'b1};
                        cnt_next = cnt_reg + 1'b1;
                    end
                    heap_end_next = heap_end_reg + TOT_W'(grow_reg);
                    free_next     = free_reg + TOT_W'(grow_reg) - TOT_W'(HEADER_BYTES);
                    grown_next    = 1'b1;
                    i_next        = '0;
                    state_next    = S_FF_RD;
                end
                else
                begin
                    status_next = ST_NO_MEM;
                    state_next  = S_DONE;
                end
            end
            S_SPLIT:
            begin
                rem = e_reg.size - s_reg;
                if (rem > SIZE_W'(HEADER_BYTES + SPLIT_SLACK))
                begin
                    if (cnt_reg >= CNT_W'(MAX_BLOCKS))
                    begin
                        status_next = ST_NO_MEM;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        new_next = '{start: START_W'(SIZE_W'(e_reg.start)
                                            + SIZE_W'(HEADER_BYTES) + s_reg),
                                     size: rem - SIZE_W'(HEADER_BYTES), free: 1'b1};
                        e_next.size = s_reg;
                        i_next      = cnt_reg - 1'b1;
                        state_next  = S_IS_RD;
                    end
                end
                else
                begin
                    state_next = S_ALLOC_K;
                end
            end
            S_IS_RD:
            begin
                rd_addr = i_reg[IDX_W-1:0];
                if (i_reg <= CNT_W'(k_reg))
                begin
                    state_next = S_IS_NEW;
                end
                else
                begin
                    state_next = S_IS_WR;
                end
            end
            S_IS_WR:
            begin
                mem_we     = 1'b1;
                mem_wa     = IDX_W'(i_reg + 1'b1);
                mem_wd     = rd_q;
                i_next     = i_reg - 1'b1;
                state_next = S_IS_RD;
            end
            S_IS_NEW:
            begin
                mem_we     = 1'b1;
                mem_wa     = k_reg + 1'b1;
                mem_wd     = new_reg;
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_ALLOC_K;
            end
            S_ALLOC_K:
            begin
                mem_we      = 1'b1;
                mem_wa      = k_reg;
                mem_wd      = '{start: e_reg.start, size: e_reg.size, free: 1'b0};
                used_next   = used_reg + TOT_W'(e_reg.size);
                free_next   = free_reg - TOT_W'(e_reg.size);
                status_next = ST_OK;
                off_next    = ADDR_W'(e_reg.start + START_W'(HEADER_BYTES));
                if (moving_reg)
                begin
                    purpose_next = P_MOVEFREE;
                    i_next       = '0;
                    state_next   = S_AD_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FR_ST:
            begin
                used_next   = used_reg - TOT_W'(e_reg.size);
                free_next   = free_reg + TOT_W'(e_reg.size);
                e_next.free = 1'b1;
                status_next = ST_OK;
                if (purpose_reg == P_MOVEFREE)
                begin
                    moved_next = 1'b1;
                end
                else
                begin
                    off_next = '0;
                end
                rd_addr = k_reg + 1'b1;
                if (CNT_W'(k_reg) + 1'b1 < cnt_reg)
                begin
                    state_next = S_FR_NX;
                end
                else
                begin
                    state_next = S_FR_PVRD;
                end
            end
            S_FR_NX:
            begin
                if (rd_q.free)
                begin
                    e_next.size  = e_reg.size + SIZE_W'(HEADER_BYTES) + rd_q.size;
                    i_next       = CNT_W'(k_reg) + CNT_W'(2);
                    rm_done_next = 1'b0;
                    state_next   = S_RM_RD;
                end
                else
                begin
                    state_next = S_FR_PVRD;
                end
            end
            S_FR_PVRD:
            begin
                rd_addr = k_reg - 1'b1;
                if (k_reg != '0)
                begin
                    state_next = S_FR_PV;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_wa     = k_reg;
                    mem_wd     = e_reg;
                    state_next = S_DONE;
                end
            end
            S_FR_PV:
            begin
                mem_we = 1'b1;
                if (rd_q.free)
                begin
                    mem_wa       = k_reg - 1'b1;
                    mem_wd       = '{start: rd_q.start,
                                     size: rd_q.size + SIZE_W'(HEADER_BYTES) + e_reg.size,
                                     free: 1'b1};
                    i_next       = CNT_W'(k_reg) + 1'b1;
                    rm_done_next = 1'b1;
                    state_next   = S_RM_RD;
                end
                else
                begin
                    mem_wa     = k_reg;
                    mem_wd     = e_reg;
                    state_next = S_DONE;
                end
            end
            S_RM_RD:
            begin
                rd_addr = i_reg[IDX_W-1:0];
                if (i_reg >= cnt_reg)
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = rm_done_reg ? S_DONE : S_FR_PVRD;
                end
                else
                begin
                    state_next = S_RM_WR;
                end
            end
            S_RM_WR:
            begin
                mem_we     = 1'b1;
                mem_wa     = IDX_W'(i_reg - 1'b1);
                mem_wd     = rd_q;
                i_next     = i_reg + 1'b1;
                state_next = S_RM_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_DATA_W'({free_reg, used_reg,
                                     (status_reg == ST_OK) ? moved_reg : 1'b0,
                                     (status_reg == ST_OK) ? off_reg : ADDR_W'(0),
                                     status_reg});
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            purpose_reg   <= P_FREE;
            moving_reg    <= 1'b0;
            grown_reg     <= 1'b0;
            rm_done_reg   <= 1'b0;
            cnt_reg       <= CNT_W'(1);
            i_reg         <= '0;
            k_reg         <= '0;
            heap_end_reg  <= TOT_W'(INIT_ROUND);
            used_reg      <= '0;
            free_reg      <= TOT_W'(INIT_ROUND - HEADER_BYTES);
            limit_reg     <= LIMIT_RESET;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            purpose_reg   <= purpose_next;
            moving_reg    <= moving_next;
            grown_reg     <= grown_next;
            rm_done_reg   <= rm_done_next;
            cnt_reg       <= cnt_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            heap_end_reg  <= heap_end_next;
            used_reg      <= used_next;
            free_reg      <= free_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg        <= e_next;
        new_reg      <= new_next;
        req_reg      <= req_next;
        addr_reg     <= addr_next;
        s_reg        <= s_next;
        grow_reg     <= grow_next;
        off_reg      <= off_next;
        moved_reg    <= moved_next;
        out_data_reg <= out_data_next;
    end

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for first_fit_heap_allocator, with a directed table, then
// random allocate/free/resize traffic across several heap limits; depends on ffha_pkg
`default_nettype none
module tb;
    import ffha_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam longint unsigned MASK27 = 64'h7FF_FFFF;
    localparam longint CYCLE_LIMIT = 50000000;
    localparam int RANDOM_ITEMS = 1930;

    typedef struct {
        status_t        status;
        bit [25:0]      offset;
        bit             moved;
        bit [26:0]      used;
        bit [26:0]      free;
    } reply_t;

    typedef struct {
        action_t        act;
        longint unsigned req;
        bit             has;
        longint unsigned addr;
        bit             typed;
        status_t        st;
        longint unsigned off;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [TOT_W-1:0]      cfg_data;

    first_fit_heap_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // heap table mirror
    bit [31:0]   blk_start [TABLE_DEPTH];
    bit [31:0]   blk_size  [TABLE_DEPTH];
    bit          blk_free  [TABLE_DEPTH];
    int unsigned blk_count;
    bit [31:0]   heap_top;
    bit [31:0]   used_sum;
    bit [31:0]   free_sum;
    bit [31:0]   heap_limit;

    reply_t pending_replies[$];
    int     errors;
    longint cycles;
    bit     quiet;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout", $time);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic longint unsigned round_to(longint unsigned v, longint unsigned a);
        return ((v + a - 1) / a) * a;
    endfunction

    function automatic int find_payload(longint unsigned addr);
        for (int i = 0; i < blk_count; i++)
            if (longint'(blk_start[i]) + HEADER_BYTES == addr)
                return i;
        return -1;
    endfunction

    function automatic int first_fit(longint unsigned s);
        for (int i = 0; i < blk_count; i++)
            if (blk_free[i] && blk_size[i] >= s)
                return i;
        return -1;
    endfunction

    function automatic void open_slot(int pos);
        for (int i = blk_count; i > pos; i--)
        begin
            blk_start[i] = blk_start[i-1];
            blk_size[i]  = blk_size[i-1];
            blk_free[i]  = blk_free[i-1];
        end
        blk_count++;
    endfunction

    function automatic void close_slot(int pos);
        for (int i = pos; i < blk_count - 1; i++)
        begin
            blk_start[i] = blk_start[i+1];
            blk_size[i]  = blk_size[i+1];
            blk_free[i]  = blk_free[i+1];
        end
        blk_count--;
    endfunction

    function automatic void heap_reset();
        longint unsigned init;
        init = round_to(INITIAL_BYTES, PAGE_BYTES);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            blk_start[i] = 0;
            blk_size[i]  = 0;
            blk_free[i]  = 0;
        end
        blk_size[0] = 32'(init - HEADER_BYTES);
        blk_free[0] = 1'b1;
        blk_count   = 1;
        heap_top    = 32'(init);
        used_sum    = 0;
        free_sum    = 32'(init - HEADER_BYTES);
        heap_limit  = 32'(LIMIT_RESET);
    endfunction

    function automatic status_t grant_block(longint unsigned req, output longint unsigned off);
        longint unsigned s, rem, grow;
        int i, k, last;
        off = 0;
        if (req == 0)
            return ST_NULL_REQ;
        s = round_to(req, ALIGN_BYTES);
        i = first_fit(s);
        if (i < 0)
        begin
            grow = s + HEADER_BYTES;
            last = blk_count - 1;
            if (grow < PAGE_BYTES)
                grow = PAGE_BYTES;
            grow = round_to(grow, PAGE_BYTES);
            if (longint'(heap_top) + grow > heap_limit)
                return ST_NO_MEM;
            if (blk_free[last])
                blk_size[last] = 32'(blk_size[last] + grow);
            else
            begin
                if (blk_count >= TABLE_DEPTH)
                    return ST_NO_MEM;
                blk_start[blk_count] = heap_top;
                blk_size[blk_count]  = 32'(grow - HEADER_BYTES);
                blk_free[blk_count]  = 1'b1;
                blk_count++;
            end
            heap_top = 32'((heap_top + grow) & MASK27);
            free_sum = 32'((free_sum + grow - HEADER_BYTES) & MASK27);
            i = first_fit(s);
            if (i < 0)
                return ST_NO_MEM;
        end
        k = i;
        rem = blk_size[k] - s;
        if (rem > HEADER_BYTES + SPLIT_SLACK)
        begin
            if (blk_count >= TABLE_DEPTH)
                return ST_NO_MEM;
            open_slot(k + 1);
            blk_start[k+1] = 32'(blk_start[k] + HEADER_BYTES + s);
            blk_size[k+1]  = 32'(rem - HEADER_BYTES);
            blk_free[k+1]  = 1'b1;
            blk_size[k]    = 32'(s);
        end
        blk_free[k] = 1'b0;
        used_sum = 32'((used_sum + blk_size[k]) & MASK27);
        free_sum = 32'((free_sum - blk_size[k]) & MASK27);
        off = longint'(blk_start[k]) + HEADER_BYTES;
        return ST_OK;
    endfunction

    function automatic void release_block(int k);
        blk_free[k] = 1'b1;
        used_sum = 32'((used_sum - blk_size[k]) & MASK27);
        free_sum = 32'((free_sum + blk_size[k]) & MASK27);
        if (k + 1 < blk_count && blk_free[k+1])
        begin
            blk_size[k] = blk_size[k] + HEADER_BYTES + blk_size[k+1];
            close_slot(k + 1);
        end
        if (k > 0 && blk_free[k-1])
        begin
            blk_size[k-1] = blk_size[k-1] + HEADER_BYTES + blk_size[k];
            close_slot(k);
        end
    endfunction

    function automatic reply_t heap_request(action_t act, longint unsigned req, bit has,
                                            longint unsigned addr);
        reply_t r;
        longint unsigned off;
        status_t st;
        int idx;
        bit mv;
        off = 0;
        st = ST_NULL_REQ;
        mv = 0;
        if (act == ACT_ALLOC)
            st = grant_block(req, off);
        else if (act == ACT_FREE)
        begin
            if (has)
            begin
                idx = find_payload(addr);
                if (idx < 0 || blk_free[idx])
                    st = ST_BAD_ADDR;
                else
                begin
                    release_block(idx);
                    st = ST_OK;
                end
            end
        end
        else if (act == ACT_RESIZE)
        begin
            if (!has)
                st = grant_block(req, off);
            else if (req != 0)
            begin
                idx = find_payload(addr);
                if (idx < 0 || blk_free[idx])
                    st = ST_BAD_ADDR;
                else if (blk_size[idx] >= req)
                begin
                    st = ST_OK;
                    off = addr;
                end
                else
                begin
                    st = grant_block(req, off);
                    if (st == ST_OK)
                    begin
                        idx = find_payload(addr);
                        if (idx >= 0)
                            release_block(idx);
                        mv = 1;
                    end
                end
            end
        end
        if (st != ST_OK)
        begin
            off = 0;
            mv = 0;
        end
        r.status = st;
        r.offset = 26'(off);
        r.moved  = mv;
        r.used   = 27'(used_sum);
        r.free   = 27'(free_sum);
        return r;
    endfunction

    // random payload offset of a live block, or 0 if none
    function automatic longint unsigned pick_live();
        int live[$];
        for (int i = 0; i < blk_count; i++)
            if (!blk_free[i])
                live.push_back(i);
        if (live.size() == 0)
            return 0;
        return longint'(blk_start[live[$urandom_range(live.size() - 1)]]) + HEADER_BYTES;
    endfunction

    task automatic send_request(row_t row);
        logic [IN_DATA_W-1:0] beat;
        reply_t r;
        @(negedge clk);
        if (!quiet && $urandom_range(99) < 31)
        begin
            s_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < 31);
        end
        beat = '0;
        beat[1:0]   = row.act;
        beat[28:2]  = row.req[26:0];
        beat[54:29] = row.addr[25:0];
        s_tdata  <= beat;
        s_tuser  <= row.has;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        r = heap_request(row.act, row.req[26:0], row.has, row.addr[25:0]);
        if (row.typed)
        begin
            r.status = row.st;
            r.offset = 26'(row.off);
        end
        pending_replies.push_back(r);
    endtask

    task automatic drain_and_set_limit(bit [26:0] lim);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_data  <= lim;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        heap_limit = 32'(lim);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic row_t random_row();
        row_t row;
        int pick, sz;
        row.typed = 0;
        row.st = ST_OK;
        row.off = 0;
        row.has = 1;
        row.addr = pick_live();
        pick = $urandom_range(99);
        sz = $urandom_range(99);
        if (sz < 75)
            row.req = $urandom_range(2048, 1);
        else if (sz < 95)
            row.req = $urandom_range(70000, 1);
        else if (sz < 98)
            row.req = $urandom_range(4000000, 1);
        else
            row.req = $urandom & MASK27;
        if (pick < 45)
            row.act = ACT_ALLOC;
        else if (pick < 75)
            row.act = ACT_FREE;
        else if (pick < 93)
        begin
            row.act = ACT_RESIZE;
            if (pick < 78)
                row.has = 0;
        end
        else
        begin
            row.act = action_t'($urandom_range(3));
            row.has = $urandom_range(1);
            row.addr = $urandom & 64'h3FF_FFFF;
            if ($urandom_range(3) == 0)
                row.req = 0;
        end
        return row;
    endfunction

    always @(posedge clk)
    begin
        reply_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t unexpected response %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                e = pending_replies.pop_front();
                if (m_tdata[1:0] != e.status)
                begin
                    $display("%0t status exp %0d got %0d", $time, e.status, m_tdata[1:0]);
                    errors++;
                end
                if (m_tdata[27:2] != e.offset)
                begin
                    $display("%0t offset exp %0d got %0d", $time, e.offset, m_tdata[27:2]);
                    errors++;
                end
                if (m_tdata[28] != e.moved)
                begin
                    $display("%0t moved exp %0d got %0d", $time, e.moved, m_tdata[28]);
                    errors++;
                end
                if (m_tdata[55:29] != e.used)
                begin
                    $display("%0t used exp %0d got %0d", $time, e.used, m_tdata[55:29]);
                    errors++;
                end
                if (m_tdata[82:56] != e.free)
                begin
                    $display("%0t free exp %0d got %0d", $time, e.free, m_tdata[82:56]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_tready <= quiet || ($urandom_range(99) >= 31);
        end
    end

    row_t directed[$];
    bit [26:0] limits[5];

    initial
    begin
        errors    = 0;
        cycles    = 0;
        quiet     = 0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        heap_reset();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed = '{
            '{ACT_ALLOC,  0,          0, 0,          1, ST_NULL_REQ, 0},
            '{ACT_ALLOC,  1,          0, 0,          1, ST_OK,       40},
            '{ACT_ALLOC,  100,        1, 0,          1, ST_OK,       96},
            '{ACT_FREE,   0,          0, 40,         1, ST_NULL_REQ, 0},
            '{ACT_FREE,   0,          1, 12345,      1, ST_BAD_ADDR, 0},
            '{ACT_FREE,   0,          1, 40,         1, ST_OK,       0},
            '{ACT_FREE,   0,          1, 40,         1, ST_BAD_ADDR, 0},
            '{ACT_NONE,   5,          1, 96,         1, ST_NULL_REQ, 0},
            '{ACT_RESIZE, 0,          1, 96,         1, ST_NULL_REQ, 0},
            '{ACT_RESIZE, 32,         0, 0,          0, ST_OK,       0},
            '{ACT_RESIZE, 112,        1, 96,         1, ST_OK,       96},
            '{ACT_RESIZE, 113,        1, 96,         0, ST_OK,       0},
            '{ACT_RESIZE, 16,         1, 96,         1, ST_BAD_ADDR, 0},
            '{ACT_ALLOC,  67108864,   0, 0,          1, ST_NO_MEM,   0},
            '{ACT_ALLOC,  134217727,  1, 67108863,   1, ST_NO_MEM,   0},
            '{ACT_FREE,   134217727,  1, 67108863,   1, ST_BAD_ADDR, 0},
            '{ACT_RESIZE, 5,          1, 67108863,   1, ST_BAD_ADDR, 0},
            '{ACT_ALLOC,  60000,      0, 0,          0, ST_OK,       0},
            '{ACT_ALLOC,  200000,     0, 0,          0, ST_OK,       0},
            '{ACT_RESIZE, 4000000,    0, 0,          0, ST_OK,       0},
            '{ACT_ALLOC,  15,         0, 0,          0, ST_OK,       0}
        };
        foreach (directed[i])
            send_request(directed[i]);

        // limit below heap end, max, random, mid, max again
        limits[0] = 27'd65536;
        limits[1] = 27'd67108864;
        limits[2] = 27'($urandom_range(67108864, 65536));
        limits[3] = 27'd1048576;
        limits[4] = 27'd67108864;
        for (int p = 0; p < 5; p++)
        begin
            drain_and_set_limit(limits[p]);
            for (int n = 0; n < RANDOM_ITEMS / 5; n++)
            begin
                quiet = (p == 2 && n >= 100 && n < 300);
                send_request(random_row());
            end
            quiet = 0;
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire

>>> first_fit_heap_allocator.f
src/ffha_pkg.sv
src/first_fit_heap_allocator.sv
tb/sv/tb.sv
